// ===== sv/mee_pkg.sv =====
`default_nettype none

package mee_pkg;

	// default configuration
	localparam int FRAC_BITS_DEF  = 60;
	localparam int COUNT_BITS_DEF = 16;

	// fixed field widths
	localparam int DATA_W  = 64;
	localparam int HALF_W  = 32;
	localparam int ACC_W   = 128;
	localparam int LIMIT_W = 16;
	localparam int OUT_W   = 16;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd2000;

	// partial product schedule, one 32x32 product per step
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_RR_LL = 4'd0;
	localparam logic [STEP_W-1:0] STEP_RR_LH = 4'd1;
	localparam logic [STEP_W-1:0] STEP_RR_HH = 4'd2;
	localparam logic [STEP_W-1:0] STEP_II_LL = 4'd3;
	localparam logic [STEP_W-1:0] STEP_II_LH = 4'd4;
	localparam logic [STEP_W-1:0] STEP_II_HH = 4'd5;
	localparam logic [STEP_W-1:0] STEP_RI_LL = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RI_LH = 4'd7;
	localparam logic [STEP_W-1:0] STEP_RI_HL = 4'd8;
	localparam logic [STEP_W-1:0] STEP_RI_HH = 4'd9;
	localparam logic [STEP_W-1:0] STEP_LAST  = STEP_RI_HH;

	// controller to datapath commands
	typedef struct packed {
		logic              load;
		logic              start;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              update;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic escaped;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== sv/mee_dp.sv =====
`default_nettype none

module mee_dp #(
	parameter int FRAC_BITS = mee_pkg::FRAC_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire mee_pkg::dp_cmd_t           cmd,
	output mee_pkg::dp_status_t             status,
	input  wire [mee_pkg::DATA_W-1:0]       point_real,
	input  wire [mee_pkg::DATA_W-1:0]       point_imag
);

	localparam int DW = mee_pkg::DATA_W;
	localparam int HW = mee_pkg::HALF_W;
	localparam int AW = mee_pkg::ACC_W;
	localparam logic [AW-1:0] FOUR = (AW)'(1) << (2 * FRAC_BITS + 2);

	function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
		mag = x[DW-1] ? (~x + (DW)'(1)) : x;
	endfunction

	// signed add that clamps to the 64-bit range
	function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
		logic [DW:0] s;
		s = {a[DW-1], a} + {b[DW-1], b};
		if (s[DW] != s[DW-1])
			sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		else
			sat_add = s[DW-1:0];
	endfunction

	logic [DW-1:0] cr_q, ci_q, zr_q, zi_q;
	logic [DW-1:0] mr_q, mi_q;
	logic          cross_neg_q;
	logic [HW-1:0] op_a, op_b;
	logic [DW-1:0] prod_s1;
	logic [mee_pkg::STEP_W-1:0] step_s1;
	logic          acc_en_s1;
	logic [AW-1:0] term;
	logic          to_r, to_i, to_x;
	logic [AW-1:0] sq_sum_q, sq_diff_q, cross_q;

	// operand halves for the current step
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.step)
			mee_pkg::STEP_RR_LL: begin op_a = mr_q[HW-1:0]; op_b = mr_q[HW-1:0]; end
			mee_pkg::STEP_RR_LH: begin op_a = mr_q[HW-1:0]; op_b = mr_q[DW-1:HW]; end
			mee_pkg::STEP_RR_HH: begin op_a = mr_q[DW-1:HW]; op_b = mr_q[DW-1:HW]; end
			mee_pkg::STEP_II_LL: begin op_a = mi_q[HW-1:0]; op_b = mi_q[HW-1:0]; end
			mee_pkg::STEP_II_LH: begin op_a = mi_q[HW-1:0]; op_b = mi_q[DW-1:HW]; end
			mee_pkg::STEP_II_HH: begin op_a = mi_q[DW-1:HW]; op_b = mi_q[DW-1:HW]; end
			mee_pkg::STEP_RI_LL: begin op_a = mr_q[HW-1:0]; op_b = mi_q[HW-1:0]; end
			mee_pkg::STEP_RI_LH: begin op_a = mr_q[HW-1:0]; op_b = mi_q[DW-1:HW]; end
			mee_pkg::STEP_RI_HL: begin op_a = mr_q[DW-1:HW]; op_b = mi_q[HW-1:0]; end
			mee_pkg::STEP_RI_HH: begin op_a = mr_q[DW-1:HW]; op_b = mi_q[DW-1:HW]; end
			default: begin op_a = '0; op_b = '0; end
		endcase
	end

	// shared 32x32 multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= (DW)'(op_a) * (DW)'(op_b);
		step_s1 <= cmd.step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.mul_en;
		end
	end

	// place the product and pick its accumulator
	always_comb begin
		term = '0;
		to_r = 1'b0;
		to_i = 1'b0;
		to_x = 1'b0;
		case (step_s1)
			mee_pkg::STEP_RR_LL: begin term = (AW)'(prod_s1); to_r = 1'b1; end
			mee_pkg::STEP_RR_LH: begin term = (AW)'(prod_s1) << (HW + 1); to_r = 1'b1; end
			mee_pkg::STEP_RR_HH: begin term = (AW)'(prod_s1) << DW; to_r = 1'b1; end
			mee_pkg::STEP_II_LL: begin term = (AW)'(prod_s1); to_i = 1'b1; end
			mee_pkg::STEP_II_LH: begin term = (AW)'(prod_s1) << (HW + 1); to_i = 1'b1; end
			mee_pkg::STEP_II_HH: begin term = (AW)'(prod_s1) << DW; to_i = 1'b1; end
			mee_pkg::STEP_RI_LL: begin term = (AW)'(prod_s1); to_x = 1'b1; end
			mee_pkg::STEP_RI_LH: begin term = (AW)'(prod_s1) << HW; to_x = 1'b1; end
			mee_pkg::STEP_RI_HL: begin term = (AW)'(prod_s1) << HW; to_x = 1'b1; end
			mee_pkg::STEP_RI_HH: begin term = (AW)'(prod_s1) << DW; to_x = 1'b1; end
			default: begin term = '0; end
		endcase
	end

	// accumulators: |z|^2, zr^2 - zi^2 and signed zr*zi
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sq_sum_q  <= '0;
			sq_diff_q <= '0;
			cross_q   <= '0;
		end else if (acc_en_s1) begin
			if (to_r || to_i)
				sq_sum_q <= sq_sum_q + term;
			if (to_r)
				sq_diff_q <= sq_diff_q + term;
			else if (to_i)
				sq_diff_q <= sq_diff_q - term;
			if (to_x)
				cross_q <= cross_neg_q ? (cross_q - term) : (cross_q + term);
		end
	end

	// point capture, magnitudes per iteration, z update
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cr_q <= point_real;
			ci_q <= point_imag;
			zr_q <= '0;
			zi_q <= '0;
		end else if (cmd.update) begin
			zi_q <= sat_add(cross_q[FRAC_BITS+DW-2 -: DW], ci_q);
			zr_q <= sat_add(sq_diff_q[FRAC_BITS+DW-1 -: DW], cr_q);
		end
		if (cmd.start) begin
			mr_q        <= mag(zr_q);
			mi_q        <= mag(zi_q);
			cross_neg_q <= zr_q[DW-1] ^ zi_q[DW-1];
		end
	end

	// escape test on the exact sum of squares
	assign status.escaped = sq_sum_q > FOUR;

endmodule

`default_nettype wire

// ===== sv/mee_ctrl.sv =====
`default_nettype none

module mee_ctrl #(
	parameter int COUNT_BITS = mee_pkg::COUNT_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [mee_pkg::LIMIT_W-1:0]       cfg_data,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [mee_pkg::OUT_W-1:0]        m_tdata,
	output logic                             m_tuser,
	output mee_pkg::dp_cmd_t                 cmd,
	input  wire mee_pkg::dp_status_t         status
);

	localparam int LW = (COUNT_BITS < mee_pkg::LIMIT_W) ? COUNT_BITS : mee_pkg::LIMIT_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_DECIDE = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]                   state_q;
	logic [mee_pkg::LIMIT_W-1:0]  limit_cfg_q;
	logic [COUNT_BITS-1:0]        limit;
	logic [COUNT_BITS-1:0]        iter_q;
	logic [mee_pkg::STEP_W-1:0]   step_q;
	logic [mee_pkg::OUT_W-1:0]    res_count_q;
	logic                         res_inside_q;
	logic                         m_tvalid_q;
	logic                         out_load;

	assign limit     = (COUNT_BITS)'(limit_cfg_q[LW-1:0]);
	assign s_tready  = (state_q == ST_IDLE);
	// limit only changes between points
	assign cfg_ready = (state_q == ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign out_load  = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);

	// datapath commands
	always_comb begin
		cmd.load   = s_tvalid && (state_q == ST_IDLE);
		cmd.start  = (state_q == ST_CHECK) && (iter_q != limit);
		cmd.mul_en = (state_q == ST_MUL);
		cmd.step   = step_q;
		cmd.update = (state_q == ST_DECIDE) && !status.escaped;
	end

	// iteration sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			limit_cfg_q  <= mee_pkg::LIMIT_RESET;
			iter_q       <= '0;
			step_q       <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_cfg_q <= cfg_data;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						iter_q  <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					if (iter_q == limit)
						state_q <= ST_FINISH;
					else
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					step_q <= step_q + (mee_pkg::STEP_W)'(1);
					if (step_q == mee_pkg::STEP_LAST)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (status.escaped) begin
						state_q <= ST_FINISH;
					end else begin
						iter_q  <= iter_q + (COUNT_BITS)'(1);
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result capture and output register
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && iter_q == limit) begin
			res_count_q  <= (mee_pkg::OUT_W)'(iter_q);
			res_inside_q <= 1'b1;
		end else if (state_q == ST_DECIDE && status.escaped) begin
			res_count_q  <= (mee_pkg::OUT_W)'(iter_q);
			res_inside_q <= 1'b0;
		end
		if (out_load) begin
			m_tdata <= res_count_q;
			m_tuser <= res_inside_q;
		end
	end

endmodule

`default_nettype wire

// ===== sv/mandelbrot_escape_time.sv =====
`default_nettype none

// Mandelbrot escape-time engine. Each input item is a point c, real part in s_tdata[63:0]
// and imaginary part in s_tdata[127:64], both signed fixed point with FRAC_BITS fraction
// bits (Q4.60 by default). The block iterates z = z*z + c from z = 0 up to iteration_limit
// times (set through the cfg port between points, reset value 2000) and returns one item
// per point: the step at which |z|^2 first exceeded 4 in m_tdata, or the limit with m_tuser
// set when the point never escaped. The escape test uses exact squares; z updates saturate.
// All the 64x64 products of one iteration run through a single shared 32x32 multiplier as
// ten partial products; each iteration passes through the check, multiply, drain and
// decide states in that order. One point is worked on at a time; the next point is
// accepted as soon as the previous result sits in the output register.
module mandelbrot_escape_time #(
	parameter int FRAC_BITS  = mee_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = mee_pkg::COUNT_BITS_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [2*mee_pkg::DATA_W-1:0]   s_tdata,   // point_real, point_imag
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [mee_pkg::OUT_W-1:0]     m_tdata,   // escape_count
	output logic                          m_tuser,   // inside_set
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [mee_pkg::LIMIT_W-1:0]    cfg_data   // iteration_limit
);

	mee_pkg::dp_cmd_t    cmd;
	mee_pkg::dp_status_t status;

	// sequencer and iteration counter
	mee_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.status   (status)
	);

	// z registers, shared multiplier and accumulators
	mee_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.point_real(s_tdata[mee_pkg::DATA_W-1:0]),
		.point_imag(s_tdata[2*mee_pkg::DATA_W-1:mee_pkg::DATA_W])
	);

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

	localparam int FRAC = mee_pkg::FRAC_BITS_DEF;
	localparam int WATCHDOG_CYCLES = 100000;
	localparam int HOLD_AT_RESULT = 60;
	localparam int HOLD_CYCLES = 300;
	localparam int N_DIRECTED = 20;
	localparam int N_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int PAUSE_AT_ITEM = 130;

	// |z|^2 escape bound, 4.0 with 2*FRAC fraction bits
	localparam logic [129:0] ESCAPE_BOUND = 130'd1 << (2 * FRAC + 2);

	// handy Q4.60 values
	localparam logic signed [63:0] ZERO      = 64'sh0000_0000_0000_0000;
	localparam logic signed [63:0] MAX_Q     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] MIN_Q     = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q     = 64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] MINUS_ONE = 64'shF000_0000_0000_0000;
	localparam logic signed [63:0] TWO_Q     = 64'sh2000_0000_0000_0000;
	localparam logic signed [63:0] MINUS_TWO = 64'shE000_0000_0000_0000;
	localparam logic signed [63:0] TWO_PLUS  = 64'sh2000_0000_0000_0001;
	localparam logic signed [63:0] QUARTER   = 64'sh0400_0000_0000_0000;
	localparam logic signed [63:0] HALF_Q    = 64'sh0800_0000_0000_0000;
	localparam logic signed [63:0] MINUS_3_4 = 64'shF400_0000_0000_0000;
	localparam logic signed [63:0] MINUS_3_2 = 64'shE800_0000_0000_0000;
	localparam logic signed [63:0] TENTH     = 64'sh0199_9999_9999_999A;
	localparam logic signed [63:0] POINT_3   = 64'sh04CC_CCCC_CCCC_CCCD;
	// random window around the set: re in [-2.25, 0.75), im in [-1.5, 1.5)
	localparam logic signed [63:0] REAL_LO   = 64'shDC00_0000_0000_0000;
	localparam logic [63:0]        SPAN_Q    = 64'h3000_0000_0000_0000;

	typedef struct packed {
		logic [15:0] count;
		logic        in_set;
	} escape_t;

	typedef struct packed {
		logic [15:0]        limit;
		logic signed [63:0] re;
		logic signed [63:0] im;
		logic               typed_in;
		logic [15:0]        count;
		logic               in_set;
	} point_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                s_tvalid = 1'b0;
	logic                                s_tready;
	logic [2*mee_pkg::DATA_W-1:0]        s_tdata = '0;   // point_real, point_imag
	logic                                m_tvalid;
	logic                                m_tready = 1'b0;
	logic [mee_pkg::OUT_W-1:0]           m_tdata;        // escape_count
	logic                                m_tuser;        // inside_set
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [mee_pkg::LIMIT_W-1:0]         cfg_data = '0;  // iteration_limit

	escape_t     pending_escapes[$];
	point_row_t  directed_rows[N_DIRECTED];
	logic [15:0] current_limit = mee_pkg::LIMIT_RESET;
	int          fails = 0;
	int          points_sent = 0;
	int          results_seen = 0;
	int          escaped_seen = 0;
	int          in_set_seen = 0;
	int          limits_written = 0;
	int          idle_cycles = 0;

	mandelbrot_escape_time dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// signed 64-bit add that clamps instead of wrapping
	function automatic logic signed [63:0] clamp_add(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? MIN_Q : MAX_Q;
		return s[63:0];
	endfunction

	// escape step of point c under the given limit
	function automatic escape_t predict_escape(input logic signed [63:0] cr,
			input logic signed [63:0] ci, input logic [15:0] limit);
		logic signed [63:0]  zr;
		logic signed [63:0]  zi;
		logic signed [127:0] wr;
		logic signed [127:0] wi;
		logic signed [127:0] sq_r;
		logic signed [127:0] sq_i;
		logic signed [127:0] cross_p;
		logic signed [127:0] diff;
		logic [129:0]        mag2;
		escape_t             res;
		zr = ZERO;
		zi = ZERO;
		res.count = limit;
		res.in_set = 1'b1;
		for (int n = 0; n < int'(limit); n++) begin
			wr = zr;
			wi = zi;
			sq_r = wr * wr;
			sq_i = wi * wi;
			mag2 = {2'b00, sq_r} + {2'b00, sq_i};
			if (mag2 > ESCAPE_BOUND) begin
				res.count = n[15:0];
				res.in_set = 1'b0;
				return res;
			end
			cross_p = (wr * wi) <<< 1;
			diff = sq_r - sq_i;
			zi = clamp_add(cross_p[FRAC+63:FRAC], ci);
			zr = clamp_add(diff[FRAC+63:FRAC], cr);
		end
		return res;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly points near the set, some on the radius-2 ring, some raw noise
	task automatic make_point(output logic signed [63:0] re, output logic signed [63:0] im);
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			re = REAL_LO + ((rand64() >> 2) % SPAN_Q);
			im = MINUS_3_2 + ((rand64() >> 2) % SPAN_Q);
		end else if (kind == 7) begin
			re = ($urandom_range(0, 1) ? TWO_Q : MINUS_TWO) + $signed(64'($urandom_range(0, 6)) - 3);
			im = $signed(rand64()) >>> 24;
		end else begin
			re = rand64();
			im = rand64();
		end
	endtask

	// offer one point, wait for the accept, then queue its result
	task automatic send_point(input logic signed [63:0] re, input logic signed [63:0] im,
			input escape_t want);
		int gap;
		gap = (points_sent % 64 < 16) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {im, re};
		do @(posedge clk); while (!s_tready);
		pending_escapes.push_back(want);
		points_sent++;
	endtask

	// stop offering and let every queued result come out
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_escapes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		current_limit = value;
		limits_written++;
	endtask

	// stimulus: directed rows, then random phases under several limits
	initial begin
		point_row_t         row;
		escape_t            want;
		logic signed [63:0] re;
		logic signed [63:0] im;
		logic [15:0]        phase_limits[N_PHASES];
		directed_rows = '{
			// reset limit: origin, extremes, the radius-2 boundary, a few points in and around the set
			'{16'd2000,  ZERO,      ZERO,      1'b1, 16'd2000, 1'b1},
			'{16'd2000,  MAX_Q,     MAX_Q,     1'b1, 16'd1,    1'b0},
			'{16'd2000,  MIN_Q,     MIN_Q,     1'b1, 16'd1,    1'b0},
			'{16'd2000,  MIN_Q,     MAX_Q,     1'b1, 16'd1,    1'b0},
			'{16'd2000,  MINUS_TWO, ZERO,      1'b1, 16'd2000, 1'b1},
			'{16'd2000,  TWO_Q,     ZERO,      1'b1, 16'd2,    1'b0},
			'{16'd2000,  ZERO,      TWO_Q,     1'b1, 16'd2,    1'b0},
			'{16'd2000,  QUARTER,   ZERO,      1'b0, 16'd0,    1'b0},
			'{16'd2000,  ONE_Q,     ZERO,      1'b0, 16'd0,    1'b0},
			'{16'd2000,  MINUS_ONE, ZERO,      1'b0, 16'd0,    1'b0},
			'{16'd2000,  MINUS_3_4, TENTH,     1'b0, 16'd0,    1'b0},
			'{16'd2000,  POINT_3,   HALF_Q,    1'b0, 16'd0,    1'b0},
			// zero limit: no step runs, even for far points
			'{16'd0,     ZERO,      ZERO,      1'b1, 16'd0,    1'b1},
			'{16'd0,     MAX_Q,     MIN_Q,     1'b1, 16'd0,    1'b1},
			// one step: z = 0 never escapes
			'{16'd1,     MAX_Q,     ZERO,      1'b1, 16'd1,    1'b1},
			'{16'd1,     ZERO,      ZERO,      1'b1, 16'd1,    1'b1},
			// widest limit, only points that leave early
			'{16'd65535, TWO_PLUS,  ZERO,      1'b1, 16'd1,    1'b0},
			'{16'd65535, MINUS_3_2, HALF_Q,    1'b0, 16'd0,    1'b0},
			'{16'd65535, ONE_Q,     ZERO,      1'b0, 16'd0,    1'b0},
			'{16'd65535, MIN_Q,     ZERO,      1'b1, 16'd1,    1'b0}
		};
		phase_limits = '{16'd3, 16'd17, 16'd64, 16'd255, 16'd0, 16'd0};
		phase_limits[4] = 16'($urandom_range(1, 300));
		phase_limits[5] = 16'($urandom_range(2, 40));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		for (int k = 0; k < N_DIRECTED; k++) begin
			row = directed_rows[k];
			if (row.limit != current_limit)
				write_limit(row.limit);
			if (row.typed_in) begin
				want.count = row.count;
				want.in_set = row.in_set;
			end else begin
				want = predict_escape(row.re, row.im, current_limit);
			end
			send_point(row.re, row.im, want);
		end

		// random phases
		for (int p = 0; p < N_PHASES; p++) begin
			write_limit(phase_limits[p]);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				// one mid-phase pause until the block is empty
				if (points_sent == N_DIRECTED + PAUSE_AT_ITEM)
					drain();
				make_point(re, im);
				send_point(re, im, predict_escape(re, im, current_limit));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d points (%0d directed) under %0d limit writes incl. 0 and 65535",
			points_sent, N_DIRECTED, limits_written);
		$display("checked %0d results: %0d escaped, %0d stayed in the set",
			results_seen, escaped_seen, in_set_seen);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, one long hold-off, compare with the oldest prediction
	initial begin
		escape_t want;
		int      stall;
		bit      held;
		held = 1'b0;
		forever begin
			stall = (results_seen % 50 < 12) ? 0 : $urandom_range(0, 8);
			if (!held && results_seen == HOLD_AT_RESULT) begin
				stall = HOLD_CYCLES;
				held = 1'b1;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(arst_n && m_tvalid));
			results_seen++;
			if (m_tuser)
				in_set_seen++;
			else
				escaped_seen++;
			if (pending_escapes.size() == 0) begin
				$error("result with nothing pending: escape_count %0d inside_set %0b",
					m_tdata, m_tuser);
				fails++;
			end else begin
				want = pending_escapes.pop_front();
				if (m_tdata !== want.count) begin
					$error("escape_count: expected %0d, got %0d", want.count, m_tdata);
					fails++;
				end
				if (m_tuser !== want.in_set) begin
					$error("inside_set: expected %0b, got %0b", want.in_set, m_tuser);
					fails++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("timeout: no handshake for %0d cycles, %0d results still pending",
				idle_cycles, pending_escapes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/mee_pkg.sv
sv/mee_dp.sv
sv/mee_ctrl.sv
sv/mandelbrot_escape_time.sv
tb/testbench.sv
